// File: sv/rrbs_pkg.sv
// shared types and constants for the round-robin ready batch selector
// holds the command codes, field widths and the search result struct
// no dependencies
package rrbs_pkg;

  localparam int IdW  = 3;
  localparam int CntW = 4;
  localparam int CfgW = 4;
  localparam int IdSpan = 2 ** IdW;

  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  typedef enum logic [2:0] {
    CMD_MARK_READY     = 3'd0,
    CMD_MARK_NOT_READY = 3'd1,
    CMD_ADVANCE        = 3'd2,
    CMD_DROP_ADVANCE   = 3'd3,
    CMD_RUN_QUERY      = 3'd4
  } cmd_e;

  typedef struct packed {
    logic           found;
    logic [IdW-1:0] slot;
  } pick_t;

endpackage

// File: sv/round_robin_ready_batch_selector.sv
// an accepted input beat passes the command register and then the result register
// one beat per cycle while out_stall_i does not hold the output; the command register feeds the
// combinational flag update and rotating search, whose result lands in the output register
// reset: ready flags cleared, owner invalid at slot 0, batches_in_use at 8
// depends on rrbs_pkg and rrbs_pick
module round_robin_ready_batch_selector #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rrbs_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                cmd_i,
  input  logic [rrbs_pkg::IdW-1:0]  batch_id_i,
  input  logic                      force_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rrbs_pkg::IdW-1:0]  owner_id_o,
  output logic                      owner_valid_o,
  output logic [rrbs_pkg::CntW-1:0] ready_count_o,
  output logic                      may_run_o,
  output logic                      none_ready_o,
  output logic                      bad_id_o
);
  import rrbs_pkg::*;

  localparam int NumFlags = (MAX_SLOTS < IdSpan) ? MAX_SLOTS : IdSpan;

  // configuration and selector state
  logic [CfgW-1:0]     biu_q;
  logic [NumFlags-1:0] flags_q, flags_d;
  logic [IdW-1:0]      owner_q, owner_d;
  logic                present_q, present_d;

  // command register
  logic           s1_valid_q;
  cmd_e           s1_cmd_q;
  logic [IdW-1:0] s1_id_q;
  logic           s1_force_q;

  // result register
  logic            out_valid_q;
  logic [IdW-1:0]  owner_id_q;
  logic            owner_valid_q;
  logic [CntW-1:0] count_q;
  logic            may_run_q, none_q, bad_q;

  logic            out_free, s1_fire, s1_load;
  logic [CfgW-1:0] n_eff, m_eff, start_w;
  logic [IdW-1:0]  start;
  logic [NumFlags-1:0] mask, sel, flags_mid;
  logic            id_ok;
  pick_t           pick;
  logic            may_run_d, none_d, bad_d;
  logic [CntW-1:0] count_d;
  logic [IdW-1:0]  owner_id_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign s1_load    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_load;

  // slot count limits
  always_comb begin
    if (biu_q == '0) begin
      n_eff = CfgW'(1);
    end else if (int'(biu_q) > MAX_SLOTS) begin
      n_eff = CfgW'(MAX_SLOTS);
    end else begin
      n_eff = biu_q;
    end
    m_eff = (int'(n_eff) > NumFlags) ? CfgW'(NumFlags) : n_eff;
    id_ok = {1'b0, s1_id_q} < n_eff;
    for (int i = 0; i < NumFlags; i++) begin
      mask[i] = CfgW'(i) < m_eff;
      sel[i]  = s1_id_q == IdW'(i);
    end
  end

  // search start, owner slot checked last
  always_comb begin
    start_w = present_q ? (CfgW'(owner_q) + CfgW'(1)) : '0;
    if (start_w >= m_eff) begin
      start_w = '0;
    end
    start = start_w[IdW-1:0];
  end

  assign flags_mid = (s1_cmd_q == CMD_DROP_ADVANCE) ? (flags_q & ~sel) : flags_q;

  rrbs_pick #(
    .NUM_FLAGS(NumFlags)
  ) u_pick (
    .flags_i(flags_mid & mask),
    .start_i(start),
    .pick_o (pick)
  );

  // next state
  always_comb begin
    flags_d   = flags_q;
    owner_d   = owner_q;
    present_d = present_q;
    none_d    = 1'b0;
    bad_d     = 1'b0;
    if (s1_cmd_q inside {CMD_MARK_READY, CMD_MARK_NOT_READY, CMD_DROP_ADVANCE,
                         CMD_RUN_QUERY} && !id_ok) begin
      bad_d = 1'b1;
    end else begin
      case (s1_cmd_q)
        CMD_MARK_READY: begin
          flags_d = flags_q | sel;
        end
        CMD_MARK_NOT_READY: begin
          flags_d = flags_q & ~sel;
        end
        CMD_ADVANCE, CMD_DROP_ADVANCE, CMD_RUN_QUERY: begin
          flags_d = flags_mid;
          if (s1_cmd_q != CMD_RUN_QUERY || !present_q) begin
            if (pick.found) begin
              owner_d   = pick.slot;
              present_d = 1'b1;
            end else if (s1_force_q || s1_cmd_q != CMD_ADVANCE) begin
              owner_d   = '0;
              present_d = 1'b0;
              none_d    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    count_d = '0;
    for (int i = 0; i < NumFlags; i++) begin
      count_d = count_d + CntW'(flags_d[i] && mask[i]);
    end
    owner_id_d = present_d ? owner_d : '0;
    may_run_d  = (s1_cmd_q == CMD_RUN_QUERY) && !bad_d && present_d
                 && (owner_d == s1_id_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q       <= CfgReset;
      flags_q     <= '0;
      owner_q     <= '0;
      present_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        biu_q <= cfg_wdata_i;
      end
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        flags_q   <= flags_d;
        owner_q   <= owner_d;
        present_q <= present_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_cmd_q   <= cmd_e'(cmd_i);
      s1_id_q    <= batch_id_i;
      s1_force_q <= force_req_i;
    end
    if (s1_fire) begin
      owner_id_q    <= owner_id_d;
      owner_valid_q <= present_d;
      count_q       <= count_d;
      may_run_q     <= may_run_d;
      none_q        <= none_d;
      bad_q         <= bad_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign owner_id_o    = owner_id_q;
  assign owner_valid_o = owner_valid_q;
  assign ready_count_o = count_q;
  assign may_run_o     = may_run_q;
  assign none_ready_o  = none_q;
  assign bad_id_o      = bad_q;

`ifndef NO_ASSERTIONS
  a_no_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !owner_valid_o |-> owner_id_o == '0)
    else $error("invalid owner reported with nonzero slot");

  a_none_no_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_ready_o |-> !owner_valid_o)
    else $error("none_ready with a valid owner");

  a_run_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && may_run_o |-> owner_valid_o && !bad_id_o)
    else $error("may_run without a valid owner");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_id_o |-> !none_ready_o && !may_run_o)
    else $error("bad id beat carries search flags");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(ready_count_o) <= NumFlags)
    else $error("ready count above slot count");
`endif

endmodule

// File: sv/rrbs_pick.sv
// rotating priority search over the masked ready flags
// picks the first set flag at or after the start slot, else the first below it
// depends on rrbs_pkg
module rrbs_pick #(
  parameter int NUM_FLAGS = 8
) (
  input  logic [NUM_FLAGS-1:0]     flags_i,
  input  logic [rrbs_pkg::IdW-1:0] start_i,
  output rrbs_pkg::pick_t          pick_o
);
  import rrbs_pkg::*;

  logic [NUM_FLAGS-1:0] upper;
  pick_t                res;

  always_comb begin
    for (int i = 0; i < NUM_FLAGS; i++) begin
      upper[i] = flags_i[i] && (IdW'(i) >= start_i);
    end
  end

  always_comb begin
    res.found = |flags_i;
    res.slot  = '0;
    // wrapped part first, lowest index wins
    for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
      if (flags_i[i]) begin
        res.slot = IdW'(i);
      end
    end
    if (|upper) begin
      for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
        if (upper[i]) begin
          res.slot = IdW'(i);
        end
      end
    end
  end

  assign pick_o = res;

endmodule

// File: tb/round_robin_ready_batch_selector_tb.sv
// testbench for the round-robin ready batch selector: directed, back-pressure and random tests
// predicts every result beat from its own copy of the ready flags, owner and slot count
// depends on rrbs_pkg and round_robin_ready_batch_selector
module round_robin_ready_batch_selector_tb;
  import rrbs_pkg::*;

  localparam int MaxSlots = 8;
  localparam logic [2:0] CmdReservedLo = 3'd5;
  localparam logic [2:0] CmdReservedHi = 3'd7;

  typedef struct packed {
    logic [IdW-1:0]  owner_id;
    logic            owner_valid;
    logic [CntW-1:0] ready_count;
    logic            may_run;
    logic            none_ready;
    logic            bad_id;
  } sel_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          cmd_i;
  logic [IdW-1:0]      batch_id_i;
  logic                force_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [IdW-1:0]      owner_id_o;
  logic                owner_valid_o;
  logic [CntW-1:0]     ready_count_o;
  logic                may_run_o;
  logic                none_ready_o;
  logic                bad_id_o;

  logic [MaxSlots-1:0] ready_flags;
  logic [IdW-1:0]      owner_slot;
  logic                owner_ok;
  logic [CfgW-1:0]     slots_cfg;

  sel_result_t         result_q[$];
  int                  mismatch_count = 0;
  int                  tx_idle_pct = 17;
  int                  rx_idle_pct = 17;
  int                  hold_cycles = 0;

  round_robin_ready_batch_selector #(
    .MAX_SLOTS(MaxSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .batch_id_i   (batch_id_i),
    .force_req_i  (force_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .owner_id_o   (owner_id_o),
    .owner_valid_o(owner_valid_o),
    .ready_count_o(ready_count_o),
    .may_run_o    (may_run_o),
    .none_ready_o (none_ready_o),
    .bad_id_o     (bad_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int live_slots();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > MaxSlots) return MaxSlots;
    return int'(slots_cfg);
  endfunction

  // returns 1 when a forced search finds no ready slot
  function automatic logic rotate_owner(input logic forced);
    int n;
    int cur;
    n = live_slots();
    cur = owner_ok ? int'(owner_slot) + 1 : 0;
    for (int i = 0; i < n; i++) begin
      if (cur >= n) cur = 0;
      if (ready_flags[cur]) begin
        owner_slot = IdW'(cur);
        owner_ok = 1'b1;
        return 1'b0;
      end
      cur++;
    end
    if (forced) begin
      owner_ok = 1'b0;
      owner_slot = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sel_result_t apply_cmd(input logic [2:0] cmd, input logic [IdW-1:0] id,
                                            input logic forced);
    sel_result_t r;
    int n;
    int cnt;
    r = '0;
    n = live_slots();
    cnt = 0;
    if (cmd <= CMD_RUN_QUERY && cmd != CMD_ADVANCE && int'(id) >= n) begin
      r.bad_id = 1'b1;
    end else begin
      case (cmd)
        CMD_MARK_READY: ready_flags[id] = 1'b1;
        CMD_MARK_NOT_READY: ready_flags[id] = 1'b0;
        CMD_ADVANCE: r.none_ready = rotate_owner(forced);
        CMD_DROP_ADVANCE: begin
          ready_flags[id] = 1'b0;
          r.none_ready = rotate_owner(1'b1);
        end
        CMD_RUN_QUERY: begin
          if (!owner_ok) r.none_ready = rotate_owner(1'b1);
          r.may_run = owner_ok && owner_slot == id;
        end
        default: ;
      endcase
    end
    for (int s = 0; s < n; s++) if (ready_flags[s]) cnt++;
    r.owner_id = owner_ok ? owner_slot : '0;
    r.owner_valid = owner_ok;
    r.ready_count = CntW'(cnt);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    sel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatch_count++;
      end else begin
        want = result_q.pop_front();
        check_field("owner_id", want.owner_id, owner_id_o);
        check_field("owner_valid", want.owner_valid, owner_valid_o);
        check_field("ready_count", want.ready_count, ready_count_o);
        check_field("may_run", want.may_run, may_run_o);
        check_field("none_ready", want.none_ready, none_ready_o);
        check_field("bad_id", want.bad_id, bad_id_o);
      end
    end
  end

  // receiver: random stall, or a counted hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [2:0] cmd, input logic [IdW-1:0] id,
                           input logic forced);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    batch_id_i  <= id;
    force_req_i <= forced;
    do @(posedge clk_i); while (in_stall_o);
    result_q.push_back(apply_cmd(cmd, id, forced));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_slots(input logic [CfgW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    slots_cfg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_rotation();
    send_beat(CMD_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_ADVANCE, 3'd7, 1'b1);
    send_beat(CMD_RUN_QUERY, 3'd0, 1'b0);
    send_beat(CMD_MARK_READY, 3'd0, 1'b0);
    send_beat(CMD_MARK_READY, 3'd7, 1'b1);
    send_beat(CMD_MARK_READY, 3'd3, 1'b0);
    send_beat(CMD_RUN_QUERY, 3'd5, 1'b0);
    send_beat(CMD_RUN_QUERY, 3'd0, 1'b1);
    send_beat(CMD_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_ADVANCE, 3'd0, 1'b1);
    send_beat(CMD_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_DROP_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_MARK_NOT_READY, 3'd3, 1'b0);
    send_beat(CMD_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_DROP_ADVANCE, 3'd7, 1'b0);
    send_beat(CmdReservedLo, 3'd7, 1'b1);
    send_beat(3'd6, 3'd0, 1'b0);
    send_beat(CmdReservedHi, 3'd2, 1'b1);
  endtask

  task automatic test_slot_limits();
    write_slots(4'd1);
    send_beat(CMD_MARK_READY, 3'd1, 1'b0);
    send_beat(CMD_RUN_QUERY, 3'd5, 1'b0);
    send_beat(CMD_DROP_ADVANCE, 3'd2, 1'b0);
    send_beat(CMD_ADVANCE, 3'd7, 1'b1);
    write_slots(4'd0);
    send_beat(CMD_MARK_READY, 3'd0, 1'b0);
    send_beat(CMD_MARK_NOT_READY, 3'd1, 1'b0);
    send_beat(CMD_RUN_QUERY, 3'd0, 1'b0);
    write_slots(4'd15);
    send_beat(CMD_MARK_READY, 3'd7, 1'b0);
    send_beat(CMD_MARK_READY, 3'd1, 1'b0);
    send_beat(CMD_DROP_ADVANCE, 3'd0, 1'b0);
    write_slots(4'd4);
    send_beat(CMD_ADVANCE, 3'd0, 1'b0);
    send_beat(CMD_RUN_QUERY, 3'd7, 1'b0);
    write_slots(4'd8);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_cycles = 80;
    for (int i = 0; i < 30; i++)
      send_beat(3'($urandom_range(4, 0)), 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_beat(3'($urandom_range(4, 0)), 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
    wait_drained();
    tx_idle_pct = 17;
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] phase_cfg;
    logic [2:0] cmd;
    logic [IdW-1:0] id;
    int n;
    int pick;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: phase_cfg = 4'd8;
        1: phase_cfg = 4'($urandom_range(7, 2));
        2: phase_cfg = 4'd1;
        3: phase_cfg = 4'd15;
        4: phase_cfg = 4'd0;
        default: phase_cfg = 4'($urandom_range(15, 0));
      endcase
      write_slots(phase_cfg);
      tx_idle_pct = (ph == 3) ? 0 : 17;
      rx_idle_pct = (ph == 3) ? 0 : 17;
      n = live_slots();
      for (int i = 0; i < 250; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 25) cmd = CMD_MARK_READY;
        else if (pick < 45) cmd = CMD_MARK_NOT_READY;
        else if (pick < 65) cmd = CMD_ADVANCE;
        else if (pick < 75) cmd = CMD_DROP_ADVANCE;
        else if (pick < 95) cmd = CMD_RUN_QUERY;
        else cmd = 3'($urandom_range(CmdReservedHi, CmdReservedLo));
        if ($urandom_range(99, 0) < 85) id = IdW'($urandom_range(n - 1, 0));
        else id = IdW'($urandom_range(IdSpan - 1, 0));
        send_beat(cmd, id, 1'($urandom_range(1, 0)));
      end
    end
    tx_idle_pct = 17;
    rx_idle_pct = 17;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    batch_id_i  = '0;
    force_req_i = 1'b0;
    ready_flags = '0;
    owner_slot  = '0;
    owner_ok    = 1'b0;
    slots_cfg   = CfgReset;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_rotation();
    test_slot_limits();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
